>>> rtl/framebuffer_pixel_writer_core_assert.svh
// assertion macros for the rtl files, used by framebuffer_pixel_writer_core
`ifndef FRAMEBUFFER_PIXEL_WRITER_CORE_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_WRITER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fpw assertion failed");

// next-cycle implication, checked out of reset
`define FPW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fpw assertion failed");

`endif

>>> rtl/fpw_pkg.sv
// ----------------------------------------------------------------------------
// fpw_pkg
// shared constants, codes and types of the framebuffer pixel writer
// ----------------------------------------------------------------------------
package fpw_pkg;

    localparam int FB_BYTES = 16384;
    localparam int FB_AW    = $clog2(FB_BYTES);
    // linear byte address before the range check
    localparam int LIN_W    = 19;
    // signed width for coordinates after rotation and mirror
    localparam int SC_W     = 12;

    // function codes
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_ROTATION = 3'd0;
    localparam logic [2:0] CFG_MIRROR   = 3'd1;
    localparam logic [2:0] CFG_BPP      = 3'd2;
    localparam logic [2:0] CFG_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_HEIGHT   = 3'd4;

    // rotation codes
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // pixel masks, msb first
    localparam logic [7:0] PIX1_MASK = 8'h80;
    localparam logic [7:0] PIX2_MASK = 8'hC0;

    typedef struct packed {
        logic [1:0] rotation;
        logic [1:0] mirror_mode;
        logic       bits_per_pixel_mode;
        logic [8:0] canvas_width;
        logic [8:0] canvas_height;
    } fpw_cfg_t;

    typedef struct packed {
        logic rot_en;
        logic mir_en;
    } fpw_xform_ctl_t;

endpackage

>>> rtl/fpw_xform.sv
// ----------------------------------------------------------------------------
// fpw_xform
// two-stage coordinate rotation, mirror and bounds check
// ----------------------------------------------------------------------------
module fpw_xform
    import fpw_pkg::*;
(
    input  logic           aclk,
    input  fpw_cfg_t       cfg,
    input  fpw_xform_ctl_t ctl,
    input  logic [7:0]     pos_x,
    input  logic [7:0]     pos_y,
    output logic [8:0]     px,
    output logic [8:0]     py,
    output logic           oob
);

    logic signed [SC_W-1:0] w_s, h_s, x_s, y_s;
    logic signed [SC_W-1:0] rx_next, ry_next, mx_next, my_next;
    logic signed [SC_W-1:0] rx_reg, ry_reg;
    logic                   in_oob_next, in_oob_reg, oob_next;
    logic [8:0]             px_reg, py_reg;
    logic                   oob_reg;

    assign w_s = signed'(SC_W'(cfg.canvas_width));
    assign h_s = signed'(SC_W'(cfg.canvas_height));
    assign x_s = signed'(SC_W'(pos_x));
    assign y_s = signed'(SC_W'(pos_y));

    // stage one: input bounds and rotation
    always_comb begin
        in_oob_next = ({1'b0, pos_x} >= cfg.canvas_width) ||
                      ({1'b0, pos_y} >= cfg.canvas_height);
        unique case (cfg.rotation)
            ROT_90: begin
                rx_next = h_s - 1 - y_s;
                ry_next = x_s;
            end
            ROT_180: begin
                rx_next = w_s - 1 - x_s;
                ry_next = h_s - 1 - y_s;
            end
            ROT_270: begin
                rx_next = y_s;
                ry_next = w_s - 1 - x_s;
            end
            default: begin
                rx_next = x_s;
                ry_next = y_s;
            end
        endcase
    end

    // stage two: mirror and transformed bounds
    always_comb begin
        mx_next  = cfg.mirror_mode[0] ? (w_s - 1 - rx_reg) : rx_reg;
        my_next  = cfg.mirror_mode[1] ? (h_s - 1 - ry_reg) : ry_reg;
        oob_next = in_oob_reg || (mx_next < 0) || (my_next < 0) ||
                   (mx_next >= w_s) || (my_next >= h_s);
    end

    always_ff @(posedge aclk) begin
        if (ctl.rot_en) begin
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            in_oob_reg <= in_oob_next;
        end
        if (ctl.mir_en) begin
            px_reg  <= mx_next[8:0];
            py_reg  <= my_next[8:0];
            oob_reg <= oob_next;
        end
    end

    assign px  = px_reg;
    assign py  = py_reg;
    assign oob = oob_reg;

endmodule

>>> rtl/fpw_frame_ram.sv
// ----------------------------------------------------------------------------
// fpw_frame_ram
// single-port synchronous ram, registered read data held across writes
// ----------------------------------------------------------------------------
module fpw_frame_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/framebuffer_pixel_writer_core.sv
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_core
// packed framebuffer with rotated, mirrored pixel draws and byte access
// ----------------------------------------------------------------------------
// usage:
//   input stream s_axis: one transfer per item, tuser holds the function
//   (draw pixel, read byte, write byte), tdata the coordinates, colour,
//   byte address and byte value. output stream m_axis: one transfer per
//   item, tdata the byte read (zero otherwise), tuser the status.
//   sequence: after the input transfer the sequencer steps each item
//   through rotate, mirror, address, ram read and ram write, and the
//   result is registered in the output register; input is ready only in idle.
//   the single ram port carries one read and at most one write per item, and only
//   one item is in flight, so no forwarding is needed.
//   configuration: plain write port, index 0 rotation, 1 mirror mode,
//   2 bits per pixel, 3 canvas width, 4 canvas height; write only when idle.
//   reset: registers return to 0/0/0/200/200; the frame store is not
//   cleared, a byte reads as undefined until written; no clearing pass.
//   stall: a result waits in the output register; a finished item holds in
//   its write step (ram not yet written) until the output register is free.
// ----------------------------------------------------------------------------
`include "framebuffer_pixel_writer_core_assert.svh"

module framebuffer_pixel_writer_core
    import fpw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pos_x[7:0], pos_y[15:8], pixel_color[17:16], byte_addr[31:18],
    //        byte_value[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: read_data[7:0]
    output logic [7:0]  m_axis_tdata,
    // tuser: status[0]
    output logic        m_axis_tuser
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MIR  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_RMW  = 3'd5;

    logic [2:0]  state_reg, state_next;
    fpw_cfg_t    cfg_reg;

    // held item fields
    logic [1:0]       func_reg;
    logic [7:0]       pos_x_reg, pos_y_reg;
    logic [1:0]       color_reg;
    logic [13:0]      byte_addr_reg;
    logic [7:0]       byte_value_reg;

    // address stage
    logic [FB_AW-1:0] addr_reg, addr_next;
    logic             status_reg, status_next;
    logic [9:0]       w_plus3, w_plus7;
    logic [7:0]       stride, word;
    logic [16:0]      row_off;
    logic [LIN_W-1:0] lin_addr;

    // transform outputs
    fpw_xform_ctl_t   xf_ctl;
    logic [8:0]       xf_px, xf_py;
    logic             xf_oob;

    // ram and modify
    logic             ram_en, ram_we;
    logic [7:0]       ram_wdata, ram_rdata;
    logic [2:0]       slot_shift;
    logic [7:0]       mask1, mask2, new_byte;
    logic             do_write, push;

    // output register
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_status_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotation            <= '0;
            cfg_reg.mirror_mode         <= '0;
            cfg_reg.bits_per_pixel_mode <= 1'b0;
            cfg_reg.canvas_width        <= 9'd200;
            cfg_reg.canvas_height       <= 9'd200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROTATION: cfg_reg.rotation            <= cfg_wdata[1:0];
                CFG_MIRROR:   cfg_reg.mirror_mode         <= cfg_wdata[1:0];
                CFG_BPP:      cfg_reg.bits_per_pixel_mode <= cfg_wdata[0];
                CFG_WIDTH:    cfg_reg.canvas_width        <= cfg_wdata;
                CFG_HEIGHT:   cfg_reg.canvas_height       <= cfg_wdata;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // item capture on input transfer
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            func_reg       <= s_axis_tuser;
            pos_x_reg      <= s_axis_tdata[7:0];
            pos_y_reg      <= s_axis_tdata[15:8];
            color_reg      <= s_axis_tdata[17:16];
            byte_addr_reg  <= s_axis_tdata[31:18];
            byte_value_reg <= s_axis_tdata[39:32];
        end
    end

    // rotate then mirror, one stage each
    assign xf_ctl.rot_en = (state_reg == ST_ROT);
    assign xf_ctl.mir_en = (state_reg == ST_MIR);

    fpw_xform u_xform (
        .aclk  (aclk),
        .cfg   (cfg_reg),
        .ctl   (xf_ctl),
        .pos_x (pos_x_reg),
        .pos_y (pos_y_reg),
        .px    (xf_px),
        .py    (xf_py),
        .oob   (xf_oob)
    );

    // byte address: row stride times row plus byte within row
    always_comb begin
        w_plus3  = {1'b0, cfg_reg.canvas_width} + 10'd3;
        w_plus7  = {1'b0, cfg_reg.canvas_width} + 10'd7;
        if (cfg_reg.bits_per_pixel_mode) begin
            stride = w_plus3[9:2];
            word   = {1'b0, xf_px[8:2]};
        end else begin
            stride = {1'b0, w_plus7[9:3]};
            word   = {2'b0, xf_px[8:3]};
        end
        row_off  = xf_py * stride;
        lin_addr = LIN_W'(row_off) + LIN_W'(word);

        unique case (func_reg)
            FUNC_DRAW: begin
                addr_next   = lin_addr[FB_AW-1:0];
                status_next = xf_oob || (lin_addr >= LIN_W'(FB_BYTES));
            end
            FUNC_READ, FUNC_WRITE: begin
                addr_next   = byte_addr_reg[FB_AW-1:0];
                status_next = (LIN_W'(byte_addr_reg) >= LIN_W'(FB_BYTES));
            end
            default: begin
                // unused function code: flagged in the status, no write
                addr_next   = byte_addr_reg[FB_AW-1:0];
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            addr_reg   <= addr_next;
            status_reg <= status_next;
        end
    end

    // modify the byte just read
    always_comb begin
        slot_shift = {xf_px[1:0], 1'b0};
        mask2      = PIX2_MASK >> slot_shift;
        mask1      = PIX1_MASK >> xf_px[2:0];
        if (func_reg == FUNC_WRITE) begin
            new_byte = byte_value_reg;
        end else if (cfg_reg.bits_per_pixel_mode) begin
            new_byte = (ram_rdata & ~mask2) | ({color_reg, 6'b0} >> slot_shift);
        end else if (color_reg == 2'd0) begin
            new_byte = ram_rdata & ~mask1;  // black clears the bit
        end else begin
            new_byte = ram_rdata | mask1;
        end
    end

    assign do_write  = !status_reg && ((func_reg == FUNC_DRAW) || (func_reg == FUNC_WRITE));
    // result leaves the sequencer once the output register can take it
    assign push      = (state_reg == ST_RMW) && (!out_valid_reg || m_axis_tready);
    assign ram_we    = push && do_write;
    assign ram_en    = (state_reg == ST_READ) || ram_we;
    assign ram_wdata = new_byte;

    fpw_frame_ram #(
        .ADDR_W (FB_AW),
        .DATA_W (8)
    ) u_frame_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_ROT;
            ST_ROT:  state_next = ST_MIR;
            ST_MIR:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_RMW;
            ST_RMW:  if (push) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_data_reg   <= ((func_reg == FUNC_READ) && !status_reg) ? ram_rdata : 8'd0;
            out_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // an accepted item always enters the rotate step
    `FPW_ASSERT_NEXT(a_accept_rot, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        state_reg == ST_ROT)
    // the frame store is written only from the write step of a valid item
    `FPW_ASSERT_NOW(a_write_ok, aclk, aresetn, ram_we,
        (state_reg == ST_RMW) && !status_reg)
    // every item that leaves the write step shows a result
    `FPW_ASSERT_NEXT(a_push_shown, aclk, aresetn, push, m_axis_tvalid)

endmodule
